[rtl/core/trma_pkg.sv]
// Shared types and constants for the thinned running mean accumulator.
package trma_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_THIN   = 2'd0;
  localparam logic [1:0] REG_BURNIN = 2'd1;
  localparam logic [1:0] REG_TRACK  = 2'd2;

  // Q1.16 one for the nonzero fraction
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // Stored entry width: mean, square mean, inclusion fraction
  localparam int unsigned ENTRY_W = 32 + 48 + 17;

  typedef struct packed {
    logic [15:0] thin;
    logic [31:0] burnin;
    logic        track;
  } trma_cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic               acc;
    logic               in_range;
    logic [9:0]         elem;
    logic signed [31:0] value;
    logic [32:0]        k;
  } trma_item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } trma_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } trma_front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_MUL,
    B_START,
    B_WAIT,
    B_DONE
  } trma_back_state_t;

endpackage

[rtl/core/trma_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module trma_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] shreg;
  logic [DW-1:0] part;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // one trial subtraction
  assign trial = {part, shreg[NW-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      part  <= '0;
    end else if (busy) begin
      shreg <= {shreg[NW-2:0], fits};
      part  <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quo = shreg;
  assign rem = part;

endmodule

[rtl/core/trma_front.sv]
// Front end: accepts items, applies thinning and burn-in, forms the count.
module trma_front (
  input  logic                  clk,
  input  logic                  rst,
  input  trma_pkg::trma_cfg_t    cfg,
  input  trma_pkg::trma_status_t status,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [79:0]           s_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output trma_pkg::trma_item_t   q_item,
  input  logic [16:0]           num_elements
);
  import trma_pkg::*;

  trma_front_state_t state, state_next;

  logic        take;
  logic [15:0] thin;
  logic [31:0] iter_q, burn_q;
  logic [15:0] iter_r, burn_r;
  logic        iter_busy, burn_busy;
  logic [9:0]  elem;
  logic signed [31:0] value;
  logic        in_range;
  logic        ge_burn;
  logic [31:0] n;

  assign thin = (cfg.thin == 16'd0) ? 16'd1 : cfg.thin;

  // iteration / thin and its remainder
  trma_div #(.NW(32), .DW(16)) u_div_iter (
    .clk(clk), .rst(rst), .start(take), .num(s_tdata[31:0]), .den(thin),
    .busy(iter_busy), .quo(iter_q), .rem(iter_r)
  );

  // burn-in / thin
  trma_div #(.NW(32), .DW(16)) u_div_burn (
    .clk(clk), .rst(rst), .start(take), .num(cfg.burnin), .den(thin),
    .busy(burn_busy), .quo(burn_q), .rem(burn_r)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (take) state_next = F_DIV;
      F_DIV:   if (!iter_busy && !burn_busy) state_next = F_PUSH;
      F_PUSH:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    q_push   = 1'b0;
    case (state)
      F_IDLE:  s_tready = !status.clearing;
      F_PUSH:  q_push = !q_full;
      default: ;
    endcase
  end

  assign take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  // item fields held while dividing
  always_ff @(posedge clk) begin
    if (take) begin
      elem     <= s_tdata[41:32];
      value    <= $signed(s_tdata[73:42]);
      in_range <= {7'd0, s_tdata[41:32]} < num_elements;
      ge_burn  <= s_tdata[31:0] >= cfg.burnin;
    end
  end

  assign n = iter_q - burn_q;

  always_comb begin
    q_item.acc      = in_range && ge_burn && (iter_r == 16'd0);
    q_item.in_range = in_range;
    q_item.elem     = elem;
    q_item.value    = value;
    q_item.k        = {1'b0, n} + 33'd1;
  end

endmodule

[rtl/core/trma_queue.sv]
// Two-entry queue between front and back.
module trma_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  trma_pkg::trma_item_t push_item,
  input  logic                pop,
  output trma_pkg::trma_item_t head,
  output logic                full,
  output logic                empty
);
  import trma_pkg::*;

  trma_item_t  slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

[rtl/core/trma_back.sv]
// Back end: element store, square, count dividers and result register.
module trma_back #(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  trma_pkg::trma_cfg_t     cfg,
  output trma_pkg::trma_status_t  status,
  input  trma_pkg::trma_item_t    head,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [111:0]           m_tdata,
  output logic                   m_tuser
);
  import trma_pkg::*;

  localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

  trma_back_state_t state, state_next;

  logic [ENTRY_W-1:0] mem [NUM_ELEMENTS];
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      rd_addr, item_addr, wr_addr;
  logic [16:0]        elem_ext;
  logic [16:0]        item_ext;
  logic               mem_we;

  trma_item_t         item;
  logic signed [31:0] cur_mean;
  logic [47:0]        cur_sq;
  logic [16:0]        cur_inc;
  logic [46:0]        sq_val;
  logic [31:0]        mag;
  logic [63:0]        prod;

  logic signed [32:0] d_mean;
  logic [49:0]        d_sq;
  logic [17:0]        d_inc;
  logic [16:0]        tgt_inc;
  logic [32:0]        mag_mean;
  logic [48:0]        mag_sq;
  logic [16:0]        mag_inc;
  logic               neg_mean, neg_sq, neg_inc;

  logic               div_start;
  logic               bm, bs, bi;
  logic [32:0]        q_mean, r_mean;
  logic [48:0]        q_sq;
  logic [32:0]        r_sq;
  logic [16:0]        q_inc;
  logic [32:0]        r_inc;

  logic [33:0]        sum_mean;
  logic [49:0]        sum_sq;
  logic [17:0]        sum_inc;
  logic [31:0]        new_mean;
  logic [47:0]        new_sq;
  logic [16:0]        new_inc;

  logic               slot_free;
  logic               out_load;
  logic               clr_last;
  logic               out_acc;
  logic [9:0]         out_elem;
  logic [31:0]        out_mean;
  logic [47:0]        out_sq;
  logic [16:0]        out_inc;

  assign elem_ext  = {7'd0, head.elem};
  assign rd_addr   = elem_ext[AW-1:0];
  assign item_ext  = {7'd0, item.elem};
  assign item_addr = item_ext[AW-1:0];
  assign slot_free = !m_tvalid || m_tready;
  assign clr_last  = {{(17-AW){1'b0}}, clr_addr} == 17'(NUM_ELEMENTS - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_last) state_next = B_IDLE;
      B_IDLE:  if (!q_empty) state_next = B_MUL;
      B_MUL:   state_next = B_START;
      B_START: state_next = item.acc ? B_WAIT : B_DONE;
      B_WAIT:  if (!bm && !bs && !bi) state_next = B_DONE;
      B_DONE:  if (slot_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    status.clearing = 1'b0;
    status.busy     = state != B_IDLE;
    case (state)
      B_CLEAR: begin
        status.clearing = 1'b1;
        mem_we          = 1'b1;
      end
      B_IDLE:  q_pop = !q_empty;
      B_START: div_start = item.acc;
      B_DONE: begin
        out_load = slot_free;
        mem_we   = slot_free && item.acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // element store
  assign wr_addr = status.clearing ? clr_addr : item_addr;
  assign wr_data = status.clearing ? '0 : {new_inc, new_sq, new_mean};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // square of the sample magnitude
  assign mag  = item.value[31] ? 32'(-item.value) : item.value;
  assign prod = mag * mag;

  always_ff @(posedge clk) begin
    if (q_pop) item <= head;
    if (state == B_MUL) begin
      cur_mean <= $signed(rd_data[31:0]);
      cur_sq   <= rd_data[79:32];
      cur_inc  <= rd_data[96:80];
      sq_val   <= prod[62:16];
    end
  end

  // differences toward the new sample
  assign tgt_inc  = (item.value != 32'sd0) ? FRAC_ONE : 17'd0;
  assign d_mean   = $signed({item.value[31], item.value}) - $signed({cur_mean[31], cur_mean});
  assign d_sq     = {3'd0, sq_val} - {2'd0, cur_sq};
  assign d_inc    = {1'b0, tgt_inc} - {1'b0, cur_inc};
  assign mag_mean = d_mean[32] ? 33'(-d_mean) : d_mean;
  assign mag_sq   = d_sq[49] ? 49'(~d_sq + 50'd1) : d_sq[48:0];
  assign mag_inc  = d_inc[17] ? 17'(~d_inc + 18'd1) : d_inc[16:0];

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_mean <= d_mean[32];
      neg_sq   <= d_sq[49];
      neg_inc  <= d_inc[17];
    end
  end

  // division of each difference by the count
  trma_div #(.NW(33), .DW(33)) u_div_mean (
    .clk(clk), .rst(rst), .start(div_start), .num(mag_mean), .den(item.k),
    .busy(bm), .quo(q_mean), .rem(r_mean)
  );

  trma_div #(.NW(49), .DW(33)) u_div_sq (
    .clk(clk), .rst(rst), .start(div_start), .num(mag_sq), .den(item.k),
    .busy(bs), .quo(q_sq), .rem(r_sq)
  );

  trma_div #(.NW(17), .DW(33)) u_div_inc (
    .clk(clk), .rst(rst), .start(div_start), .num(mag_inc), .den(item.k),
    .busy(bi), .quo(q_inc), .rem(r_inc)
  );

  // updated values stay between old value and target
  assign sum_mean = {{2{cur_mean[31]}}, cur_mean}
                  + (neg_mean ? 34'(~{1'b0, q_mean} + 34'd1) : {1'b0, q_mean});
  assign sum_sq   = {2'd0, cur_sq}
                  + (neg_sq ? 50'(~{1'b0, q_sq} + 50'd1) : {1'b0, q_sq});
  assign sum_inc  = {1'b0, cur_inc}
                  + (neg_inc ? 18'(~{1'b0, q_inc} + 18'd1) : {1'b0, q_inc});
  assign new_mean = item.acc ? sum_mean[31:0] : cur_mean;
  assign new_sq   = item.acc ? sum_sq[47:0] : cur_sq;
  assign new_inc  = (item.acc && cfg.track) ? sum_inc[16:0] : cur_inc;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc  <= item.acc;
      out_elem <= item.elem;
      out_mean <= item.in_range ? new_mean : 32'd0;
      out_sq   <= item.in_range ? new_sq : 48'd0;
      out_inc  <= item.in_range ? new_inc : 17'd0;
    end
  end

  assign m_tuser = out_acc;
  assign m_tdata = {5'd0, out_inc, out_sq, out_mean, out_elem};

  a_div_only_accepted: assert property (@(posedge clk) disable iff (rst)
    (state == B_WAIT) |-> item.acc)
    else $error("dividers running for a rejected item");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !m_tvalid)
    else $error("result presented during store clearing");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == B_DONE)
    else $error("result loaded outside completion step");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty && state == B_IDLE)
    else $error("queue popped while empty or busy");

endmodule

[rtl/core/thinned_running_mean_accumulator_unit.sv]
// Thinned running mean accumulator: per-element running mean and mean of squares.
//
// Input stream s_*: one beat per sampler element, s_tdata holds iteration,
// element_index and sample_value. Output stream m_*: exactly one beat per
// input beat, in order; m_tuser flags that the item was accumulated.
// Configuration registers (thinning interval, burn-in, sparse mode) are written through
// cfg_wen/cfg_addr/cfg_wdata; the user must do so only while the block is idle, the block itself does not enforce it.
//
// The front end takes one beat at a time through its two 32-step serial
// dividers (iteration and burn-in by the interval); a two-entry queue then
// feeds the back end, which reads the element store, squares the sample and
// runs three serial dividers by the count for an accumulated beat and skips
// them for a rejected one. The front can accept the next beat while the back
// end is still working on earlier ones. Sustained throughput is set by the
// back end's dividers when accumulating and by the front for rejected beats.
//
// After reset the element store is cleared one entry per cycle; s_tready
// stays low meanwhile. When m_tready is low the result waits in the output
// register and the front keeps accepting until the queue fills.
module thinned_running_mean_accumulator_unit #(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // iteration[31:0], element_index[41:32], sample_value[73:42]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // element_echo, mean_value, square_mean_value, inclusion_fraction
  output logic         m_tuser,   // accepted
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import trma_pkg::*;

  trma_cfg_t    cfg;
  trma_status_t status;
  trma_item_t   push_item, head;
  logic         q_push, q_pop, q_full, q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thin   <= 16'd1;
      cfg.burnin <= 32'd0;
      cfg.track  <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_THIN:   cfg.thin   <= cfg_wdata[15:0];
        REG_BURNIN: cfg.burnin <= cfg_wdata;
        REG_TRACK:  cfg.track  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  trma_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .status(status),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_full(q_full), .q_push(q_push), .q_item(push_item),
    .num_elements(17'(NUM_ELEMENTS))
  );

  trma_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(push_item),
    .pop(q_pop), .head(head), .full(q_full), .empty(q_empty)
  );

  trma_back #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .status(status),
    .head(head), .q_empty(q_empty), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule
